[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is held off during reset.
`define CHK_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define CHK_NEVER(lbl, cond, msg) \
	`CHK_CLK(lbl, !(cond), msg)

`endif

[rtl/slwa_pkg.sv]
package slwa_pkg;

	localparam int MAX_RADIUS = 128;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_ZOOM   = 1'b1;

	typedef struct packed {
		logic [10:0] origin_x;
		logic [10:0] origin_y;
		logic [7:0]  col;
		logic [7:0]  row;
	} in_beat_t;

	typedef struct packed {
		logic        copy;
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [11:0] src_x;
		logic [11:0] src_y;
	} out_beat_t;

	// Per-pixel data that rides alongside the arithmetic chain.
	typedef struct packed {
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [7:0]  ax;
		logic [7:0]  ay;
		logic        pos_x;
		logic        pos_y;
		logic        in_circle;
	} side_t;

endpackage

[rtl/slwa_div_cell.sv]
module slwa_div_cell import slwa_pkg::*; #(
	parameter int QW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  side_t         side_i,
	input  logic [QW-1:0] num_i,
	input  logic [QW-1:0] quo_i,
	input  logic [16:0]   rem_i,
	input  logic [16:0]   den_i,
	output logic          valid_o,
	output side_t         side_o,
	output logic [QW-1:0] num_o,
	output logic [QW-1:0] quo_o,
	output logic [16:0]   rem_o,
	output logic [16:0]   den_o
);

	logic [17:0] trial;
	logic        fits;
	logic [17:0] diff;

	always_comb begin
		trial = {rem_i, num_i[QW-1]};
		fits  = trial >= {1'b0, den_i};
		diff  = trial - {1'b0, den_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			den_o  <= den_i;
			num_o  <= {num_i[QW-2:0], 1'b0};
			quo_o  <= {quo_i[QW-2:0], fits};
			rem_o  <= fits ? diff[16:0] : trial[16:0];
		end
	end

endmodule

[rtl/slwa_sqrt_cell.sv]
module slwa_sqrt_cell import slwa_pkg::*; #(
	parameter int SW = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_i,
	input  side_t           side_i,
	input  logic [2*SW-1:0] n_i,
	input  logic [SW-1:0]   root_i,
	input  logic [SW+1:0]   rem_i,
	output logic            valid_o,
	output side_t           side_o,
	output logic [2*SW-1:0] n_o,
	output logic [SW-1:0]   root_o,
	output logic [SW+1:0]   rem_o
);

	logic [SW+3:0] cur;
	logic [SW+3:0] trial;
	logic          fits;
	logic [SW+3:0] diff;

	// One result bit per cell: bring down two radicand bits, try 4*root+1.
	always_comb begin
		cur   = {rem_i, n_i[2*SW-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		fits  = cur >= trial;
		diff  = cur - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			n_o    <= {n_i[2*SW-3:0], 2'b00};
			root_o <= {root_i[SW-2:0], fits};
			rem_o  <= fits ? diff[SW+1:0] : cur[SW+1:0];
		end
	end

endmodule

[rtl/sphere_lens_warp_address.sv]
// Spherical lens warp address generator.
// Input channel: in_valid / in_stall carry one pixel beat (lens window origin
// and the column and row inside the window). Output channel: out_valid /
// out_stall carry one result beat per input beat: destination address,
// source address and a copy flag.
// Configuration: cfg_we writes cfg_data into register cfg_idx (radius, zoom);
// write only while no beat is in flight.
// Throughput: one beat per clock while out_stall does not hold the output. The
// pipeline is a front stage, a chain of restoring divider cells (one quotient
// bit each, 2*FRAC_BITS+16 cells), a chain of square root cells (one root
// bit each, FRAC_BITS+8 cells), a multiply stage and an output register.
// When the output beat is held by out_stall, the whole chain freezes and
// in_stall is raised until the beat is taken.
// Reset empties the chain and loads radius 75 and zoom 40.
module sphere_lens_warp_address import slwa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_idx,
	input  logic [7:0] cfg_data
);

	localparam int QW = 16 + 2 * FRAC_BITS;
	localparam int SW = QW / 2;
	localparam int PW = 8 + SW;

	logic [7:0] radius_q;
	logic [7:0] zoom_q;
	logic       en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 8'd75;
			zoom_q   <= 8'd40;
		end else if (cfg_we) begin
			if (cfg_idx == REG_RADIUS) begin
				radius_q <= cfg_data;
			end else begin
				zoom_q <= cfg_data;
			end
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Front stage: window test, distances, divisor.
	logic [7:0]  r;
	logic [7:0]  ax;
	logic [7:0]  ay;
	logic [16:0] d2;
	logic [15:0] rr;
	logic [15:0] z2;
	logic [17:0] s;
	side_t       side_c;

	always_comb begin
		r  = (32'(radius_q) > MAX_RADIUS) ? 8'(MAX_RADIUS) : radius_q;
		ax = (in_data.col >= r) ? in_data.col - r : r - in_data.col;
		ay = (in_data.row >= r) ? in_data.row - r : r - in_data.row;
		d2 = 17'(16'(ax) * 16'(ax)) + 17'(16'(ay) * 16'(ay));
		rr = 16'(r) * 16'(r);
		z2 = 16'(zoom_q) * 16'(zoom_q);
		s  = 18'(z2) + 18'(rr) - 18'(d2);
		side_c.dest_x = 12'(in_data.origin_x) + 12'(in_data.col);
		side_c.dest_y = 12'(in_data.origin_y) + 12'(in_data.row);
		side_c.ax     = ax;
		side_c.ay     = ay;
		side_c.pos_x  = in_data.col < r;
		side_c.pos_y  = in_data.row < r;
		side_c.in_circle = ({1'b0, in_data.col} < {r, 1'b0})
			&& ({1'b0, in_data.row} < {r, 1'b0}) && (d2 <= 17'(rr));
	end

	logic          valid_s1;
	side_t         side_s1;
	logic [QW-1:0] num_s1;
	logic [16:0]   den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			num_s1  <= {z2, {(2 * FRAC_BITS){1'b0}}};
			den_s1  <= s[16:0];
		end
	end

	// Divider chain: floor(zoom^2 * 4^FRAC_BITS / S).
	logic          dv_valid [0:QW];
	side_t         dv_side  [0:QW];
	logic [QW-1:0] dv_num   [0:QW];
	logic [QW-1:0] dv_quo   [0:QW];
	logic [16:0]   dv_rem   [0:QW];
	logic [16:0]   dv_den   [0:QW];

	assign dv_valid[0] = valid_s1;
	assign dv_side[0]  = side_s1;
	assign dv_num[0]   = num_s1;
	assign dv_quo[0]   = '0;
	assign dv_rem[0]   = '0;
	assign dv_den[0]   = den_s1;

	for (genvar i = 0; i < QW; i++) begin : g_div
		slwa_div_cell #(.QW(QW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (dv_valid[i]),
			.side_i  (dv_side[i]),
			.num_i   (dv_num[i]),
			.quo_i   (dv_quo[i]),
			.rem_i   (dv_rem[i]),
			.den_i   (dv_den[i]),
			.valid_o (dv_valid[i+1]),
			.side_o  (dv_side[i+1]),
			.num_o   (dv_num[i+1]),
			.quo_o   (dv_quo[i+1]),
			.rem_o   (dv_rem[i+1]),
			.den_o   (dv_den[i+1])
		);
	end

	// Square root chain gives the fixed-point shift.
	logic          sq_valid [0:SW];
	side_t         sq_side  [0:SW];
	logic [QW-1:0] sq_n     [0:SW];
	logic [SW-1:0] sq_root  [0:SW];
	logic [SW+1:0] sq_rem   [0:SW];

	assign sq_valid[0] = dv_valid[QW];
	assign sq_side[0]  = dv_side[QW];
	assign sq_n[0]     = dv_quo[QW];
	assign sq_root[0]  = '0;
	assign sq_rem[0]   = '0;

	for (genvar j = 0; j < SW; j++) begin : g_sqrt
		slwa_sqrt_cell #(.SW(SW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (sq_valid[j]),
			.side_i  (sq_side[j]),
			.n_i     (sq_n[j]),
			.root_i  (sq_root[j]),
			.rem_i   (sq_rem[j]),
			.valid_o (sq_valid[j+1]),
			.side_o  (sq_side[j+1]),
			.n_o     (sq_n[j+1]),
			.root_o  (sq_root[j+1]),
			.rem_o   (sq_rem[j+1])
		);
	end

	// Multiply stage. A zero zoom forces the shift to zero, which also
	// covers a zero divisor.
	logic [SW-1:0] q;
	logic          valid_s2;
	side_t         side_s2;
	logic [PW-1:0] prod_x_s2;
	logic [PW-1:0] prod_y_s2;

	assign q = (zoom_q == 8'd0) ? '0 : sq_root[SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sq_valid[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= sq_side[SW];
			prod_x_s2 <= PW'(sq_side[SW].ax) * PW'(q);
			prod_y_s2 <= PW'(sq_side[SW].ay) * PW'(q);
		end
	end

	// Magnitude is a - ceil(a*q / 2^FRAC_BITS), floored at zero.
	logic [PW:0]   up_x;
	logic [PW:0]   up_y;
	logic [7:0]    mx;
	logic [7:0]    my;
	out_beat_t     res;

	always_comb begin
		up_x = ((PW+1)'(prod_x_s2) + (PW+1)'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
		up_y = ((PW+1)'(prod_y_s2) + (PW+1)'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
		mx = (up_x >= (PW+1)'(side_s2.ax)) ? 8'd0 : side_s2.ax - up_x[7:0];
		my = (up_y >= (PW+1)'(side_s2.ay)) ? 8'd0 : side_s2.ay - up_y[7:0];
		if (!side_s2.in_circle) begin
			mx = 8'd0;
			my = 8'd0;
		end
		res.copy   = (mx != 8'd0) || (my != 8'd0);
		res.dest_x = side_s2.dest_x;
		res.dest_y = side_s2.dest_y;
		res.src_x  = side_s2.pos_x ? side_s2.dest_x + 12'(mx) : side_s2.dest_x - 12'(mx);
		res.src_y  = side_s2.pos_y ? side_s2.dest_y + 12'(my) : side_s2.dest_y - 12'(my);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res;
		end
	end

	logic out_moved;

	assign out_moved = (out_data.src_x != out_data.dest_x)
		|| (out_data.src_y != out_data.dest_y);

`include "assert_macros.svh"

	`CHK_CLK(a_copy_moves, out_valid && out_data.copy |-> out_moved, "copy beat with no move")
	`CHK_NEVER(a_nocopy_same, out_valid && !out_data.copy && out_moved, "moved beat without copy")
	`CHK_CLK(a_stall_keeps, out_valid && out_stall |=> out_valid && $stable(out_data), "held beat lost")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import slwa_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 3 * FRAC + 27;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;
	logic      cfg_we;
	logic      cfg_idx;
	logic [7:0] cfg_data;

	sphere_lens_warp_address #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Register copies used by the predictor.
	logic [7:0] lens_radius;
	logic [7:0] pred_zoom;

	out_beat_t warp_q[$];
	int        n_errors;
	bit        hold_long;
	bit        drain_done;

	typedef struct {
		logic [10:0] ox;
		logic [10:0] oy;
		logic [7:0]  col;
		logic [7:0]  row;
		bit          known;
		out_beat_t   res;
	} row_t;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#200ms;
		$display("tb NOT OK");
		$finish;
	end

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res;
		longint unsigned c;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if (c * c <= n)
				res = c;
		end
		return res;
	endfunction

	function automatic longint unsigned shrink(longint unsigned a, longint unsigned q);
		longint unsigned up;
		up = (a * q + (64'd1 << FRAC) - 1) >> FRAC;
		return (up >= a) ? 0 : a - up;
	endfunction

	function automatic out_beat_t warp_address(in_beat_t b);
		out_beat_t o;
		longint unsigned r, ax, ay, d2, z2, s, q, mx, my;
		r = (lens_radius > MAX_RADIUS) ? MAX_RADIUS : lens_radius;
		o.copy = 1'b0;
		o.dest_x = 12'(b.origin_x) + 12'(b.col);
		o.dest_y = 12'(b.origin_y) + 12'(b.row);
		o.src_x = o.dest_x;
		o.src_y = o.dest_y;
		if (b.col < 2 * r && b.row < 2 * r) begin
			ax = (b.col >= r) ? b.col - r : r - b.col;
			ay = (b.row >= r) ? b.row - r : r - b.row;
			d2 = ax * ax + ay * ay;
			if (d2 <= r * r) begin
				z2 = pred_zoom * pred_zoom;
				s = z2 + r * r - d2;
				q = 0;
				if (s != 0 && z2 != 0)
					q = root64((z2 << (2 * FRAC)) / s);
				mx = shrink(ax, q);
				my = shrink(ay, q);
				if (mx != 0 || my != 0) begin
					o.copy = 1'b1;
					o.src_x = (b.col < r) ? 12'(o.dest_x + mx) : 12'(o.dest_x - mx);
					o.src_y = (b.row < r) ? 12'(o.dest_y + my) : 12'(o.dest_y - my);
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [11:0] got, logic [11:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// Output side: compare each beat with the oldest expectation.
	always @(posedge clk) begin
		out_beat_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (warp_q.size() == 0) begin
				report_mismatch("unexpected beat", 12'(out_data.dest_x), 12'd0);
			end else begin
				w = warp_q.pop_front();
				if (out_data.copy !== w.copy)
					report_mismatch("copy", 12'(out_data.copy), 12'(w.copy));
				if (out_data.dest_x !== w.dest_x)
					report_mismatch("dest_x", out_data.dest_x, w.dest_x);
				if (out_data.dest_y !== w.dest_y)
					report_mismatch("dest_y", out_data.dest_y, w.dest_y);
				if (out_data.src_x !== w.src_x)
					report_mismatch("src_x", out_data.src_x, w.src_x);
				if (out_data.src_y !== w.src_y)
					report_mismatch("src_y", out_data.src_y, w.src_y);
			end
		end
	end

	// Receiver stalls: mostly short gaps, sometimes long, and one very long hold.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				for (int i = 0; i < 300; i++)
					@(posedge clk);
				out_stall <= 1'b0;
				hold_long = 1'b0;
			end else if (drain_done || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				out_stall <= 1'b1;
				for (int i = 0; i < n; i++)
					@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RADIUS)
			lens_radius = val;
		else
			pred_zoom = val;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (warp_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Offer one beat and hold it until accepted; a random gap may come first.
	task automatic send_pixel(in_beat_t b, bit known, out_beat_t res, bit gaps);
		out_beat_t w;
		int n;
		if (gaps && $urandom_range(0, 2) == 0) begin
			n = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		w = warp_address(b);
		if (known && w != res)
			$display("directed row disagrees with predictor at %0t", $realtime);
		warp_q.push_back(known ? res : w);
	endtask

	function automatic in_beat_t rand_pixel(int r);
		in_beat_t b;
		int span;
		b.origin_x = 11'($urandom);
		b.origin_y = 11'($urandom);
		span = (r > 128) ? 128 : r;
		if ($urandom_range(0, 7) == 0 || span == 0) begin
			b.col = 8'($urandom);
			b.row = 8'($urandom);
		end else begin
			b.col = 8'($urandom_range(0, 2 * span - 1));
			b.row = 8'($urandom_range(0, 2 * span - 1));
		end
		return b;
	endfunction

	initial begin
		row_t      tbl[$];
		row_t      t;
		in_beat_t  b;
		out_beat_t none;
		logic [7:0] radii[6];
		logic [7:0] zooms[6];
		radii = '{8'd1, 8'd128, 8'd255, 8'd0, 8'd20, 8'd75};
		zooms = '{8'd255, 8'd1, 8'd0, 8'd40, 8'd100, 8'd7};
		n_errors = 0;
		hold_long = 1'b0;
		drain_done = 1'b0;
		lens_radius = 8'd75;
		pred_zoom = 8'd40;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_RADIUS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset settings (radius 75, zoom 40).
		none = '0;
		tbl.push_back('{0, 0, 150, 10, 1'b1, '{1'b0, 12'd150, 12'd10, 12'd150, 12'd10}});
		tbl.push_back('{2047, 2047, 255, 255, 1'b1,
			'{1'b0, 12'd2302, 12'd2302, 12'd2302, 12'd2302}});
		tbl.push_back('{5, 5, 0, 0, 1'b1, '{1'b0, 12'd5, 12'd5, 12'd5, 12'd5}});
		tbl.push_back('{9, 9, 75, 75, 1'b1, '{1'b0, 12'd84, 12'd84, 12'd84, 12'd84}});
		tbl.push_back('{0, 0, 40, 75, 1'b0, none});
		tbl.push_back('{0, 0, 110, 75, 1'b0, none});
		tbl.push_back('{0, 0, 75, 20, 1'b0, none});
		tbl.push_back('{0, 0, 75, 130, 1'b0, none});
		tbl.push_back('{2047, 2047, 149, 149, 1'b0, none});
		tbl.push_back('{2047, 2047, 20, 140, 1'b0, none});
		tbl.push_back('{1024, 0, 128, 30, 1'b0, none});
		tbl.push_back('{0, 1024, 1, 74, 1'b0, none});
		tbl.push_back('{1365, 682, 149, 75, 1'b0, none});
		tbl.push_back('{682, 1365, 75, 0, 1'b0, none});
		foreach (tbl[i]) begin
			b.origin_x = tbl[i].ox;
			b.origin_y = tbl[i].oy;
			b.col = tbl[i].col;
			b.row = tbl[i].row;
			send_pixel(b, tbl[i].known, tbl[i].res, 1'b0);
		end
		in_valid <= 1'b0;
		wait_idle();

		// Zero zoom makes the magnitude equal the distance from centre.
		write_reg(REG_ZOOM, 8'd0);
		t = '{0, 0, 74, 75, 1'b1, '{1'b0, 12'd74, 12'd75, 12'd75, 12'd75}};
		t.res.copy = 1'b1;
		b = '{11'd0, 11'd0, 8'd74, 8'd75};
		send_pixel(b, 1'b1, t.res, 1'b0);
		// Zero radius: empty window.
		in_valid <= 1'b0;
		wait_idle();
		write_reg(REG_RADIUS, 8'd0);
		b = '{11'd3, 11'd4, 8'd0, 8'd0};
		send_pixel(b, 1'b1, '{1'b0, 12'd3, 12'd4, 12'd3, 12'd4}, 1'b0);
		in_valid <= 1'b0;
		wait_idle();

		// Random phases over several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_RADIUS, radii[ph]);
			write_reg(REG_ZOOM, zooms[ph]);
			for (int i = 0; i < 115; i++) begin
				if (ph == 2 && i == 20)
					hold_long = 1'b1;
				send_pixel(rand_pixel(radii[ph]), 1'b0, none, 1'b1);
			end
			in_valid <= 1'b0;
			// The drain between phases is the sender's pause until all results arrive.
			wait_idle();
		end

		drain_done = 1'b1;
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0 && warp_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
